[sv/event_arc_corner_detector_unit_assert.svh]
// Assertion macros for the event arc corner detector.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef EVENT_ARC_CORNER_DETECTOR_UNIT_ASSERT_SVH
`define EVENT_ARC_CORNER_DETECTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EACD_ASSERT_SAME(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");
`define EACD_ASSERT_NEXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define EACD_ASSERT_SAME(lbl, a, b)
`define EACD_ASSERT_NEXT(lbl, a, b)
`endif
`endif

[sv/eacd_pkg.sv]
// Shared types, constants and ring offset tables for the event arc corner detector.
// No dependencies.
package eacd_pkg;

   localparam int SENSOR_WIDTH_DEF  = 256;
   localparam int SENSOR_HEIGHT_DEF = 256;
   localparam int BORDER            = 4;
   localparam logic [4:0] RING3_LEN = 5'd16;
   localparam logic [4:0] RING4_LEN = 5'd20;

   localparam logic [1:0] REG_SMALL_MIN = 2'd0;
   localparam logic [1:0] REG_SMALL_MAX = 2'd1;
   localparam logic [1:0] REG_LARGE_MIN = 2'd2;
   localparam logic [1:0] REG_LARGE_MAX = 2'd3;

   localparam logic [3:0] SMALL_MIN_RST = 4'd3;
   localparam logic [3:0] SMALL_MAX_RST = 4'd6;
   localparam logic [4:0] LARGE_MIN_RST = 5'd4;
   localparam logic [4:0] LARGE_MAX_RST = 5'd8;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRITE, ST_SCAN, ST_LOAD_L, ST_LOAD_R, ST_LOAD_RW,
      ST_STEP, ST_FETCH, ST_DECIDE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [3:0] dx;
      logic signed [3:0] dy;
   } off_type;

   localparam logic signed [3:0] R3_DX [16] = '{
      4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd3, 4'sd3, 4'sd2, 4'sd1,
      4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd3, -4'sd3, -4'sd2, -4'sd1};
   localparam logic signed [3:0] R3_DY [16] = '{
      4'sd3, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3,
      -4'sd3, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3};
   localparam logic signed [3:0] R4_DX [20] = '{
      4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1,
      4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4, -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1};
   localparam logic signed [3:0] R4_DY [20] = '{
      4'sd4, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd3, -4'sd4,
      -4'sd4, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4};

   // rsel 0: radius-3 ring, index wraps mod 16; 1: radius-4 ring, no offset past it
   function automatic off_type ring_off(input logic rsel, input logic [4:0] idx);
      off_type o;
      o = '0;
      if (rsel) begin
         if (idx < RING4_LEN) begin
            o.dx = R4_DX[idx];
            o.dy = R4_DY[idx];
         end
      end else begin
         o.dx = R3_DX[idx[3:0]];
         o.dy = R3_DY[idx[3:0]];
      end
      return o;
   endfunction

endpackage

[sv/eacd_ram.sv]
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module eacd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/event_arc_corner_detector_unit.sv]
// Channel  | dir | handshake            | payload
// req      | in  | req_tvalid/tready    | tdata: pos_x, pos_y, timestamp; tuser: polarity
// rsp      | out | rsp_tvalid/tready    | tdata[0]: is_corner
// csr      | in  | csr_valid/csr_ready  | csr_index, csr_data
// One item at a time; a border or off-sensor item skips the search, a full test
// searches the radius-3 ring and, only if that passes, the radius-4 ring. Each ring
// element is one read of the single-port surface RAM; an arc step is a STEP then a
// FETCH state. After reset a clearing pass zeroes all 2 * 2^clog2(H) * 2^clog2(W)
// words (131072 at 256x256) with req_tready low. A result waits in the output register.
// Arc search and time surface; depends on eacd_pkg, eacd_ram and the assert macro header.
`include "event_arc_corner_detector_unit_assert.svh"
module event_arc_corner_detector_unit #(
   parameter int SENSOR_WIDTH  = eacd_pkg::SENSOR_WIDTH_DEF,
   parameter int SENSOR_HEIGHT = eacd_pkg::SENSOR_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [7:0] pos_x, [15:8] pos_y, [47:16] timestamp
   input  logic        req_tuser,   // [0] polarity
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] is_corner, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);
   import eacd_pkg::*;

   localparam int XW    = $clog2(SENSOR_WIDTH);
   localparam int YW    = $clog2(SENSOR_HEIGHT);
   localparam int AW    = 1 + XW + YW;
   localparam int DEPTH = 2 ** AW;
   localparam int CW    = 11;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic pol_ff, pol_in, onsens_ff, onsens_in, inside_ff, inside_in;
   logic [31:0] ts_ff, ts_in;
   logic rsel_ff, rsel_in, side_ff, side_in, res_ff, res_in;
   logic [4:0] idx_ff, idx_in, it_ff, it_in, len_ff, len_in, l_ff, l_in, r_ff, r_in;
   logic [31:0] seg_ff, seg_in, lv_ff, lv_in, rv_ff, rv_in;
   logic [31:0] lmin_ff, lmin_in, rmin_ff, rmin_in;
   logic rsp_valid_ff, rsp_valid_in, corner_ff, corner_in;
   logic [3:0] smin_ff, smax_ff;
   logic [4:0] lgmin_ff, lgmax_ff;

   logic ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0] ram_wdata, ram_rdata;

   logic [4:0] ring_n, mn, mx, ring_idx, k;
   logic [5:0] sum_mx, sum_mn;
   logic [CW-1:0] xe, ye;
   logic forced, pass;
   off_type off;

   eacd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_surface (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   function automatic logic [4:0] ring_prev(input logic [4:0] i, input logic [4:0] n);
      return (i == 5'd0) ? n - 5'd1 : i - 5'd1;
   endfunction

   function automatic logic [4:0] ring_next(input logic [4:0] i, input logic [4:0] n);
      return (i == n - 5'd1) ? 5'd0 : i + 5'd1;
   endfunction

   assign ring_n = rsel_ff ? RING4_LEN : RING3_LEN;
   assign mn = rsel_ff ? ((lgmin_ff > RING4_LEN) ? RING4_LEN : lgmin_ff) : {1'b0, smin_ff};
   assign mx = rsel_ff ? lgmax_ff : {1'b0, smax_ff};
   assign sum_mx = {1'b0, len_ff} + {1'b0, mx};
   assign sum_mn = {1'b0, len_ff} + {1'b0, mn};
   // len <= mx, or len >= n - mx and len <= n - mn, kept free of negative values
   assign pass = (len_ff <= mx) || (sum_mx >= {1'b0, ring_n} && sum_mn <= {1'b0, ring_n});
   assign forced = it_ff < mn;
   assign k = idx_ff - 5'd1;
   assign xe = CW'(req_tdata[7:0]);
   assign ye = CW'(req_tdata[15:8]);
   assign off = ring_off(rsel_ff, ring_idx);

   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, corner_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         smin_ff      <= SMALL_MIN_RST;
         smax_ff      <= SMALL_MAX_RST;
         lgmin_ff     <= LARGE_MIN_RST;
         lgmax_ff     <= LARGE_MAX_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_SMALL_MIN: smin_ff  <= csr_data[3:0];
               REG_SMALL_MAX: smax_ff  <= csr_data[3:0];
               REG_LARGE_MIN: lgmin_ff <= csr_data;
               REG_LARGE_MAX: lgmax_ff <= csr_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  y_ff <= y_in;  pol_ff <= pol_in;  ts_ff <= ts_in;
      onsens_ff <= onsens_in;  inside_ff <= inside_in;
      rsel_ff <= rsel_in;  side_ff <= side_in;  res_ff <= res_in;
      idx_ff <= idx_in;  it_ff <= it_in;  len_ff <= len_in;  l_ff <= l_in;  r_ff <= r_in;
      seg_ff <= seg_in;  lv_ff <= lv_in;  rv_ff <= rv_in;
      lmin_ff <= lmin_in;  rmin_ff <= rmin_in;  corner_ff <= corner_in;
   end

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;
      x_in = x_ff;  y_in = y_ff;  pol_in = pol_ff;  ts_in = ts_ff;
      onsens_in = onsens_ff;  inside_in = inside_ff;
      rsel_in = rsel_ff;  side_in = side_ff;  res_in = res_ff;
      idx_in = idx_ff;  it_in = it_ff;  len_in = len_ff;  l_in = l_ff;  r_in = r_ff;
      seg_in = seg_ff;  lv_in = lv_ff;  rv_in = rv_ff;
      lmin_in = lmin_ff;  rmin_in = rmin_ff;  corner_in = corner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready = 1'b0;
      ring_idx = idx_ff;
      ram_we = 1'b0;
      ram_wdata = ts_ff;
      ram_addr = {pol_ff, y_ff, x_ff};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wdata = '0;
            ram_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in = XW'(req_tdata[7:0]);
               y_in = YW'(req_tdata[15:8]);
               ts_in = req_tdata[47:16];
               pol_in = req_tuser;
               onsens_in = xe < CW'(SENSOR_WIDTH) && ye < CW'(SENSOR_HEIGHT);
               inside_in = xe >= CW'(BORDER) && xe <= CW'(SENSOR_WIDTH - 1 - BORDER) &&
                           ye >= CW'(BORDER) && ye <= CW'(SENSOR_HEIGHT - 1 - BORDER);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we = onsens_ff;
            if (inside_ff) begin
               rsel_in = 1'b0;
               idx_in = '0;
               state_in = ST_SCAN;
            end else begin
               res_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_SCAN: begin
            // read element idx, take the data of element idx-1
            ram_addr = {pol_ff, y_ff + YW'(off.dy), x_ff + XW'(off.dx)};
            if (idx_ff != 5'd0) begin
               if (k == 5'd0) begin
                  seg_in = ram_rdata;
                  r_in = '0;
               end else if (ram_rdata > seg_ff) begin
                  seg_in = ram_rdata;
                  r_in = k;
               end
            end
            idx_in = idx_ff + 5'd1;
            if (idx_ff == ring_n) begin
               state_in = ST_LOAD_L;
            end
         end
         ST_LOAD_L: begin
            ring_idx = ring_prev(r_ff, ring_n);
            ram_addr = {pol_ff, y_ff + YW'(off.dy), x_ff + XW'(off.dx)};
            l_in = ring_idx;
            r_in = ring_next(r_ff, ring_n);
            state_in = ST_LOAD_R;
         end
         ST_LOAD_R: begin
            ring_idx = r_ff;
            ram_addr = {pol_ff, y_ff + YW'(off.dy), x_ff + XW'(off.dx)};
            lv_in = ram_rdata;
            lmin_in = ram_rdata;
            state_in = ST_LOAD_RW;
         end
         ST_LOAD_RW: begin
            rv_in = ram_rdata;
            rmin_in = ram_rdata;
            it_in = 5'd1;
            len_in = mn;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (it_ff >= ring_n) begin
               state_in = ST_DECIDE;
            end else begin
               if (rv_ff > lv_ff) begin
                  if (forced || rv_ff >= seg_ff) begin
                     if (!forced) len_in = it_ff + 5'd1;
                     if (rmin_ff < seg_ff) seg_in = rmin_ff;
                  end
                  ring_idx = ring_next(r_ff, ring_n);
                  r_in = ring_idx;
                  side_in = 1'b1;
               end else begin
                  if (forced || lv_ff >= seg_ff) begin
                     if (!forced) len_in = it_ff + 5'd1;
                     if (lmin_ff < seg_ff) seg_in = lmin_ff;
                  end
                  ring_idx = ring_prev(l_ff, ring_n);
                  l_in = ring_idx;
                  side_in = 1'b0;
               end
               ram_addr = {pol_ff, y_ff + YW'(off.dy), x_ff + XW'(off.dx)};
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (side_ff) begin
               rv_in = ram_rdata;
               if (ram_rdata < rmin_ff) rmin_in = ram_rdata;
            end else begin
               lv_in = ram_rdata;
               if (ram_rdata < lmin_ff) lmin_in = ram_rdata;
            end
            it_in = it_ff + 5'd1;
            state_in = ST_STEP;
         end
         ST_DECIDE: begin
            if (pass && !rsel_ff) begin
               rsel_in = 1'b1;
               idx_in = '0;
               state_in = ST_SCAN;
            end else begin
               res_in = pass;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               corner_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `EACD_ASSERT_NEXT(a_accept_writes, req_tvalid && req_tready, state_ff == ST_WRITE)
   `EACD_ASSERT_SAME(a_iter_bound, state_ff == ST_FETCH, it_ff < ring_n)
   `EACD_ASSERT_SAME(a_len_bound, state_ff == ST_DECIDE, len_ff <= ring_n)
   `EACD_ASSERT_NEXT(a_no_extra_rsp, rsp_valid_ff && rsp_tready && state_ff != ST_EMIT,
                     !rsp_valid_ff)
   `EACD_ASSERT_SAME(a_clear_quiet, state_ff == ST_CLEAR, !rsp_valid_ff)
endmodule
